/* hw/rtl/jbc_pkg.sv */
package jbc_pkg;

	// Delimiter characters
	localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
	localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
	localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
	localparam logic [7:0] CH_QUOTE         = 8'h22;

	// Kind of an open item on the nesting stack
	localparam logic KIND_BRACE   = 1'b0;
	localparam logic KIND_BRACKET = 1'b1;

	typedef enum logic [2:0] {
		FAULT_NONE     = 3'd0,
		FAULT_MISMATCH = 3'd1,
		FAULT_EMPTY    = 3'd2,
		FAULT_UNCLOSED = 3'd3,
		FAULT_QUOTE    = 3'd4,
		FAULT_OVERFLOW = 3'd5
	} fault_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_doc;
	} text_item_t;

	typedef struct packed {
		logic       doc_valid;
		logic [2:0] fault_kind;
	} verdict_item_t;

endpackage

/* hw/rtl/jbc_stream_if.sv */
interface jbc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/jbc_stack_ram.sv */
module jbc_stack_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	// Write on push, registered read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/json_bracket_balance_checker_unit.sv */
// The result appears, registered, in the cycle after the end_of_doc byte is accepted.
// Throughput: one byte per cycle unless a pending verdict is stalled; the stack top is a
// register; the RAM read port prefetches the entry below it, so a pop never waits on it.
// Reset: arst_n clears the string flag, depth, fault code and output valid at once;
// the stack memory is not cleared, since only entries written by a push are read.
module json_bracket_balance_checker_unit
	import jbc_pkg::*;
#(
	parameter int MAX_NEST = 64
) (
	input logic clk,
	input logic arst_n,
	jbc_stream_if.sink   text,
	jbc_stream_if.source verdict
);

	localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
	localparam int DW = $clog2(MAX_NEST + 1);

	logic          in_string_q;
	logic [DW-1:0] depth_q;
	logic          top_q;
	fault_t        fault_q;

	logic          nxt_string;
	logic [DW-1:0] nxt_depth;
	logic          nxt_top;
	fault_t        nxt_fault;
	fault_t        end_fault;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic          below_top;

	logic          out_valid_q;
	verdict_item_t out_item_q;

	logic          accept;
	logic          last;
	logic          open_kind;
	logic          close_kind;

	assign text.ready = !out_valid_q || verdict.ready;
	assign accept     = text.valid && text.ready;
	assign last       = text.payload.end_of_doc;
	assign open_kind  = (text.payload.text_byte == CH_OPEN_BRACKET) ? KIND_BRACKET : KIND_BRACE;
	assign close_kind = (text.payload.text_byte == CH_CLOSE_BRACKET) ? KIND_BRACKET : KIND_BRACE;

	jbc_stack_ram #(
		.DEPTH (MAX_NEST),
		.AW    (AW)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (below_top)
	);

	// Decode one request and update the stack
	always_comb begin
		nxt_string = in_string_q;
		nxt_depth  = depth_q;
		nxt_top    = top_q;
		nxt_fault  = fault_q;
		end_fault  = fault_q;
		mem_we     = 1'b0;
		mem_waddr  = depth_q[AW-1:0];
		mem_wdata  = open_kind;

		if (accept && fault_q == FAULT_NONE) begin
			if (in_string_q) begin
				if (text.payload.text_byte == CH_QUOTE) begin
					nxt_string = 1'b0;
				end
			end else begin
				case (text.payload.text_byte)
					CH_QUOTE: begin
						nxt_string = 1'b1;
					end
					CH_OPEN_BRACE, CH_OPEN_BRACKET: begin
						if (depth_q == DW'(MAX_NEST)) begin
							nxt_fault = FAULT_OVERFLOW;
						end else begin
							mem_we    = 1'b1;
							nxt_top   = open_kind;
							nxt_depth = depth_q + DW'(1);
						end
					end
					CH_CLOSE_BRACE, CH_CLOSE_BRACKET: begin
						if (depth_q == '0) begin
							nxt_fault = FAULT_EMPTY;
						end else if (top_q != close_kind) begin
							nxt_fault = FAULT_MISMATCH;
						end else begin
							nxt_top   = below_top;
							nxt_depth = depth_q - DW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end

		// Close out the document and drop back to the reset state
		end_fault = nxt_fault;
		if (accept && last) begin
			if (nxt_fault == FAULT_NONE) begin
				if (nxt_string) begin
					end_fault = FAULT_QUOTE;
				end else if (nxt_depth != '0) begin
					end_fault = FAULT_UNCLOSED;
				end
			end
			nxt_string = 1'b0;
			nxt_depth  = '0;
			nxt_fault  = FAULT_NONE;
		end

		// Prefetch the entry below the next top
		if (nxt_depth >= DW'(2)) begin
			mem_raddr = AW'(nxt_depth - DW'(2));
		end else begin
			mem_raddr = '0;
		end
	end

	// Hold the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
			depth_q     <= '0;
			fault_q     <= FAULT_NONE;
		end else begin
			in_string_q <= nxt_string;
			depth_q     <= nxt_depth;
			fault_q     <= nxt_fault;
		end
	end

	// Top of stack copy, only meaningful while depth is nonzero
	always_ff @(posedge clk) begin
		top_q <= nxt_top;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			out_item_q.doc_valid  <= (end_fault == FAULT_NONE);
			out_item_q.fault_kind <= end_fault;
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.payload = out_item_q;

	// Checks
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_NEST))
		else $error("nesting depth above stack size");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> depth_q == '0 && !in_string_q && fault_q == FAULT_NONE)
		else $error("state not cleared after end of document");

	a_fault_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != FAULT_NONE && !(accept && last) |=> $stable(depth_q) && $stable(in_string_q))
		else $error("stack moved after a fault");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_item_q.doc_valid == (out_item_q.fault_kind == FAULT_NONE))
		else $error("valid flag disagrees with fault code");

	a_push_step: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && !last |=> depth_q == $past(depth_q) + DW'(1))
		else $error("push did not advance depth");

endmodule
